// ===== hdl/kwsc_pkg.sv =====
// Package for the keyword substitution cipher: item kind codes, the letter base,
// the controller state type and the command/status structs between controller and datapath.
// No dependencies.
package kwsc_pkg;

  // item kinds carried on in_tuser
  localparam logic [1:0] KIND_KEY = 2'd0;
  localparam logic [1:0] KIND_ENC = 2'd1;
  localparam logic [1:0] KIND_DEC = 2'd2;

  // ASCII code of the first letter of the alphabet
  localparam logic [7:0] LETTER_BASE = 8'd65;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYS,
    ST_FILL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;         // accept the item on the input channel
    logic build_start;  // load the build counters
    logic key_step;     // place the next keyword letter
    logic fill_step;    // test the next letter, place it when unused
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;       // result register can take a new item
    logic key_last_item;  // item on the input is the last key letter
    logic key_empty;      // no keyword letters kept
    logic key_end;        // current keyword letter is the final one
    logic fill_end;       // current letter is the last of the alphabet
  } sts_t;

endpackage

// ===== hdl/keyword_substitution_cipher.sv =====
// Keyword substitution cipher: top level joining controller and datapath.
// Depends on kwsc_pkg, kwsc_ctrl and kwsc_datapath.
//
// Key letters (in_tuser = 0) arrive one item at a time and give no result;
// repeats and characters outside 'A'.. are dropped. The key item with in_tlast
// set builds the cipher alphabet: the kept keyword followed by the unused letters
// in order, rotated right by the shift distance (a written distance above
// ALPHABET_SIZE-1 saturates). Encode (1) and decode (2) items give one result
// each, at one item per cycle while the result register is free and no build
// runs, letters mapped through the tables and every other character passed
// unchanged; a kind of 3 is dropped. Each result is registered and valid in the
// cycle after its item is taken. After the last key letter the build sequencer
// writes the kept keyword letters (none when the keyword is empty), then tests
// each letter of the alphabet and writes the unused ones, and holds in_tready low
// meanwhile. Text sent before a build or during key entry uses the current tables,
// identity after reset. Write the shift distance only while the block is idle.
module keyword_substitution_cipher import kwsc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       clk,
  input  logic       rst_n,
  // shift distance register
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic [1:0] in_tuser,   // [1:0] kind
  input  logic       in_tlast,   // key_last
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] char_out
);

  cmd_t cmd;
  sts_t sts;

  // acceptance and build sequencing
  kwsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // keyword store, tables and result register
  kwsc_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_kind     (in_tuser),
    .in_char     (in_tdata),
    .in_last     (in_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_char    (out_tdata)
  );

endmodule

// ===== hdl/kwsc_ctrl.sv =====
// Controller of the keyword substitution cipher: item acceptance and build sequencing.
// Depends on kwsc_pkg.
module kwsc_ctrl import kwsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = sts.out_free;
        cmd.take  = in_tvalid && sts.out_free;
        if (cmd.take && sts.key_last_item) begin
          cmd.build_start = 1'b1;
          state_nxt       = ST_KEYS;
        end
      end
      ST_KEYS: begin
        // skip straight to the fill when the keyword is empty
        if (sts.key_empty) begin
          state_nxt = ST_FILL;
        end else begin
          cmd.key_step = 1'b1;
          if (sts.key_end) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_build_enters_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && cmd.build_start) |=> (state_r == ST_KEYS))
    else $error("build start did not enter keyword placement");
`endif

endmodule

// ===== hdl/kwsc_datapath.sv =====
// Datapath of the keyword substitution cipher: keyword store, cipher and inverse
// tables, build counters and the result register. Depends on kwsc_pkg.
module kwsc_datapath import kwsc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_char
);

  localparam int IDX_W = $clog2(ALPHABET_SIZE);
  localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [4:0]       SHIFT_MAX = 5'(ALPHABET_SIZE - 1);
  localparam logic [7:0]       N_CHARS   = 8'(ALPHABET_SIZE);
  localparam logic [CNT_W-1:0] KEY_MAX   = CNT_W'(ALPHABET_SIZE);

  logic [IDX_W-1:0]         shift_r;
  logic [IDX_W-1:0]         cipher_r  [ALPHABET_SIZE];
  logic [IDX_W-1:0]         inverse_r [ALPHABET_SIZE];
  logic [IDX_W-1:0]         key_order_r [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] used_r;
  logic [CNT_W-1:0]         kp_r;
  logic                     key_complete_r;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic [IDX_W-1:0]         bi_r, bj_r;
  logic                     out_valid_r;
  logic [7:0]               out_char_r;

  // letter decode of the incoming character
  logic [7:0]       char_off;
  logic             is_letter;
  logic [IDX_W-1:0] letter_idx;

  assign char_off   = in_char - LETTER_BASE;
  assign is_letter  = (in_char >= LETTER_BASE) && (char_off < N_CHARS);
  assign letter_idx = char_off[IDX_W-1:0];

  // a key letter after a finished key starts from an empty keyword
  logic [ALPHABET_SIZE-1:0] used_eff;
  logic [CNT_W-1:0]         kp_eff;
  logic                     key_add;
  logic                     take_key;
  logic                     take_text;

  assign used_eff  = key_complete_r ? '0 : used_r;
  assign kp_eff    = key_complete_r ? '0 : kp_r;
  assign key_add   = is_letter && !used_eff[letter_idx] && (kp_eff < KEY_MAX);
  assign take_key  = cmd.take && (in_kind == KIND_KEY);
  assign take_text = cmd.take && ((in_kind == KIND_ENC) || (in_kind == KIND_DEC));

  // table write during the build
  logic             wr_en;
  logic [IDX_W-1:0] wr_val;

  always_comb begin
    wr_en  = 1'b0;
    wr_val = bj_r;
    if (cmd.key_step) begin
      wr_en  = 1'b1;
      wr_val = key_order_r[bi_r];
    end else if (cmd.fill_step) begin
      wr_en  = !used_r[bj_r];
    end
  end

  assign pos_nxt = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (cfg_wr_en) begin
      shift_r <= (cfg_wr_data > SHIFT_MAX) ? LAST_IDX : cfg_wr_data[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        cipher_r[k]  <= IDX_W'(k);
        inverse_r[k] <= IDX_W'(k);
      end
    end else if (wr_en) begin
      cipher_r[pos_r]   <= wr_val;
      inverse_r[wr_val] <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_key && key_add) begin
      key_order_r[kp_eff[IDX_W-1:0]] <= letter_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r         <= '0;
      kp_r           <= '0;
      key_complete_r <= 1'b1;
    end else if (take_key) begin
      used_r         <= key_add ? (used_eff | (ALPHABET_SIZE'(1) << letter_idx)) : used_eff;
      kp_r           <= key_add ? kp_eff + CNT_W'(1) : kp_eff;
      key_complete_r <= in_last;
    end
  end

  // build counters
  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      pos_r <= shift_r;
      bi_r  <= '0;
      bj_r  <= '0;
    end else begin
      if (wr_en) begin
        pos_r <= pos_nxt;
      end
      if (cmd.key_step) begin
        bi_r <= bi_r + IDX_W'(1);
      end
      if (cmd.fill_step) begin
        bj_r <= bj_r + IDX_W'(1);
      end
    end
  end

  // result register
  logic [IDX_W-1:0] lookup;

  assign lookup = (in_kind == KIND_ENC) ? cipher_r[letter_idx] : inverse_r[letter_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_text) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_text) begin
      out_char_r <= is_letter ? (LETTER_BASE + 8'(lookup)) : in_char;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;

  assign sts.out_free      = !out_valid_r || out_tready;
  assign sts.key_last_item = (in_kind == KIND_KEY) && in_last;
  assign sts.key_empty     = (kp_r == '0);
  assign sts.key_end       = ((CNT_W'(bi_r) + CNT_W'(1)) == kp_r);
  assign sts.fill_end      = (bj_r == LAST_IDX);

`ifndef SYNTHESIS
  a_rotation_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fill_step && sts.fill_end) |=> (pos_r == shift_r))
    else $error("table build did not place every letter exactly once");

  a_key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kp_r <= KEY_MAX)
    else $error("keyword count beyond alphabet size");

  a_key_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(kp_r))
    else $error("keyword count disagrees with letters marked used");
`endif

endmodule
